FILE: design/atu_pkg.sv
package atu_pkg;

  typedef enum logic [2:0] {
    OP_IDENTITY  = 3'd0,
    OP_WRITE     = 3'd1,
    OP_TRANSLATE = 3'd2,
    OP_SCALE     = 3'd3,
    OP_ROTX      = 3'd4,
    OP_ROTY      = 3'd5,
    OP_ROTZ      = 3'd6,
    OP_POINT     = 3'd7
  } atu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_MUL,
    ST_DRAIN,
    ST_DONE
  } atu_state_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_REDUCE,
    SC_SCALE,
    SC_FOLD,
    SC_ITER,
    SC_ROUND
  } sc_state_t;

  // Tag that travels with one column through a lane.
  typedef struct packed {
    logic       valid;
    logic [1:0] col;
  } lane_tag_t;

  // Angle datapath widths: nanodegrees and Q30 CORDIC vector.
  localparam int ZW = 41;
  localparam int XW = 34;

  localparam logic [29:0]          NANO     = 30'd1000000000;
  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
  localparam logic signed [ZW-1:0] DEG90    = ZW'(64'd90000000000);
  localparam logic signed [ZW-1:0] DEG180   = ZW'(64'd180000000000);
  localparam logic signed [ZW-1:0] DEG360   = ZW'(64'd360000000000);

  // Arctangent of 2^-i in nanodegrees.
  function automatic logic signed [ZW-1:0] atan_nd(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = ZW'(64'd45000000000);
      5'd1:  v = ZW'(64'd26565051177);
      5'd2:  v = ZW'(64'd14036243468);
      5'd3:  v = ZW'(64'd7125016349);
      5'd4:  v = ZW'(64'd3576334375);
      5'd5:  v = ZW'(64'd1789910608);
      5'd6:  v = ZW'(64'd895173710);
      5'd7:  v = ZW'(64'd447614171);
      5'd8:  v = ZW'(64'd223810500);
      5'd9:  v = ZW'(64'd111905677);
      5'd10: v = ZW'(64'd55952892);
      5'd11: v = ZW'(64'd27976453);
      5'd12: v = ZW'(64'd13988227);
      5'd13: v = ZW'(64'd6994114);
      5'd14: v = ZW'(64'd3497057);
      5'd15: v = ZW'(64'd1748528);
      5'd16: v = ZW'(64'd874264);
      5'd17: v = ZW'(64'd437132);
      5'd18: v = ZW'(64'd218566);
      5'd19: v = ZW'(64'd109283);
      5'd20: v = ZW'(64'd54642);
      5'd21: v = ZW'(64'd27321);
      5'd22: v = ZW'(64'd13660);
      5'd23: v = ZW'(64'd6830);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/atu_in_if.sv
interface atu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic signed [31:0] operand_c;
  logic [1:0]         elem_row;
  logic [1:0]         elem_col;

  modport source (output valid, opcode, operand_a, operand_b, operand_c, elem_row, elem_col,
                  input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, operand_c, elem_row, elem_col,
                  output ready);
endinterface

FILE: design/atu_out_if.sv
interface atu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

FILE: design/affine_transform_unit.sv
// Affine transform unit: holds a 4x4 homogeneous matrix in fixed point
// (FRAC_BITS fraction bits) and updates or applies it, one item at a time.
// Channel item_in takes an opcode with three operands and an element address.
// Identity and element writes finish in the cycle the item is accepted.
// Translate, scale and rotate post-multiply the matrix: four row lanes each
// handle one matrix row, one column of the right-hand factor per cycle, with
// a two-stage multiply/round pipeline. Rotations first run the sine/cosine
// unit: an angle reduction by reciprocal multiplication, a scale step and a
// fold step, CORDIC_STEPS iterations and a rounding step. A point transform
// uses a single column, after which the image appears on result_out from an
// output register. item_in is ready whenever the sequencer is idle, also
// while a result still waits on result_out. A new point transform that
// completes while the previous result has not been taken holds in its final
// state until the output register frees. Reset loads the identity matrix and
// clears all control.
module affine_transform_unit
  import atu_pkg::*;
#(
  parameter int DATA_WIDTH   = 32,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  atu_in_if.sink      item_in,
  atu_out_if.source   result_out
);

  localparam int DW = DATA_WIDTH;
  localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  // Saturate a 32-bit operand to the datapath width.
  function automatic logic signed [DW-1:0] sat_in(input logic signed [31:0] v);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = (33'sd1 <<< (DW - 1)) - 33'sd1;
    lo = -hi - 33'sd1;
    if (DW >= 32) return DW'(v);
    if (33'(v) > hi) return DW'(hi);
    if (33'(v) < lo) return DW'(lo);
    return DW'(v);
  endfunction

  // Saturate a datapath value to 32 bits.
  function automatic logic signed [31:0] sat_out(input logic signed [DW-1:0] v);
    logic signed [DW+32:0] w;
    w = (DW+33)'(v);
    if (DW <= 32) return 32'(v);
    if (w > (DW+33)'(32'sh7fffffff)) return 32'sh7fffffff;
    if (w < -(DW+33)'(64'sh80000000)) return 32'sh80000000;
    return 32'(v);
  endfunction

  atu_state_t state, state_next;

  logic signed [DW-1:0] mtx [16];
  logic signed [DW-1:0] res [4][4];
  logic signed [DW-1:0] t_mat [16];
  logic signed [DW-1:0] va, vb, vc;
  atu_op_t              op;
  logic [1:0]           col_cnt;
  logic [1:0]           last_col;

  logic                 in_acc;
  atu_op_t              in_op;
  logic                 sc_start;
  logic                 sc_done;
  logic signed [DW-1:0] cs, sn;

  lane_tag_t            issue;
  lane_tag_t            lane_tag [4];
  logic signed [DW-1:0] lane_val [4];
  logic signed [DW-1:0] m_row [4][4];
  logic signed [DW-1:0] t_col [4];
  logic                 last_back;
  logic                 out_load;

  assign in_op    = atu_op_t'(item_in.opcode);
  assign in_acc   = item_in.valid && item_in.ready;
  assign sc_start = in_acc && (in_op == OP_ROTX || in_op == OP_ROTY || in_op == OP_ROTZ);
  assign last_col = (op == OP_POINT) ? 2'd0 : 2'd3;
  assign last_back = lane_tag[0].valid && (lane_tag[0].col == last_col);
  assign out_load  = (state == ST_DONE) && (op == OP_POINT)
                     && (!result_out.valid || result_out.ready);

  assign item_in.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    issue.valid = 1'b0;
    issue.col   = col_cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_IDENTITY, OP_WRITE:    state_next = ST_IDLE;
            OP_ROTX, OP_ROTY, OP_ROTZ: state_next = ST_ANGLE;
            default:                  state_next = ST_MUL;
          endcase
        end
      end
      ST_ANGLE: if (sc_done) state_next = ST_MUL;
      ST_MUL: begin
        issue.valid = 1'b1;
        if (col_cnt == last_col) state_next = ST_DRAIN;
      end
      ST_DRAIN: if (last_back) state_next = ST_DONE;
      ST_DONE: begin
        if (op != OP_POINT || out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Right-hand factor of the product. A point transform uses its first column
  // as the homogeneous vector (x, y, z, 1).
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      t_mat[k] = (k % 5 == 0) ? ONE : '0;
    end
    unique case (op)
      OP_TRANSLATE: begin
        t_mat[3] = va; t_mat[7] = vb; t_mat[11] = vc;
      end
      OP_SCALE: begin
        t_mat[0] = va; t_mat[5] = vb; t_mat[10] = vc;
      end
      OP_ROTX: begin
        t_mat[5] = cs; t_mat[6] = -sn; t_mat[9] = sn; t_mat[10] = cs;
      end
      OP_ROTY: begin
        t_mat[0] = cs; t_mat[2] = sn; t_mat[8] = -sn; t_mat[10] = cs;
      end
      OP_ROTZ: begin
        t_mat[0] = cs; t_mat[1] = -sn; t_mat[4] = sn; t_mat[5] = cs;
      end
      OP_POINT: begin
        t_mat[0] = va; t_mat[4] = vb; t_mat[8] = vc; t_mat[12] = ONE;
        t_mat[5] = '0; t_mat[10] = '0; t_mat[15] = '0;
      end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) begin
      t_col[k] = t_mat[k * 4 + int'(col_cnt)];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op <= in_op;
      va <= sat_in(item_in.operand_a);
      vb <= sat_in(item_in.operand_b);
      vc <= sat_in(item_in.operand_c);
    end
    if (state == ST_MUL) begin
      col_cnt <= col_cnt + 2'd1;
    end else begin
      col_cnt <= '0;
    end
  end

  // Matrix store: identity at reset and on the identity opcode, element writes, and the product of a matrix operation.
  always_ff @(posedge clk) begin
    if (rst || (in_acc && in_op == OP_IDENTITY)) begin
      for (int k = 0; k < 16; k++) begin
        mtx[k] <= (k % 5 == 0) ? ONE : '0;
      end
    end else if (in_acc && in_op == OP_WRITE) begin
      mtx[{item_in.elem_row, item_in.elem_col}] <= sat_in(item_in.operand_a);
    end else if (state == ST_DONE && op != OP_POINT) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mtx[r * 4 + c] <= res[r][c];
        end
      end
    end
  end

  atu_sincos #(
    .DW    (DW),
    .FRAC  (FRAC_BITS),
    .STEPS (CORDIC_STEPS)
  ) u_sincos (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .angle (item_in.operand_a),
    .done  (sc_done),
    .cs    (cs),
    .sn    (sn)
  );

  for (genvar r = 0; r < 4; r++) begin : g_lane
    for (genvar k = 0; k < 4; k++) begin : g_tap
      assign m_row[r][k] = mtx[r * 4 + k];
    end

    atu_lane #(
      .DW   (DW),
      .FRAC (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .issue   (issue),
      .m_row   (m_row[r]),
      .t_col   (t_col),
      .res_tag (lane_tag[r]),
      .res_val (lane_val[r])
    );

    // Merge: each lane's column result lands in its row of the product.
    always_ff @(posedge clk) begin
      if (lane_tag[r].valid) begin
        res[r][lane_tag[r].col] <= lane_val[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (out_load) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
    if (out_load) begin
      result_out.point_x <= sat_out(res[0][0]);
      result_out.point_y <= sat_out(res[1][0]);
      result_out.point_z <= sat_out(res[2][0]);
    end
  end

  // Lane results only come back while a product is in flight.
  a_lane_in_flight: assert property (@(posedge clk) disable iff (rst)
    lane_tag[0].valid |-> (state == ST_MUL || state == ST_DRAIN))
    else $error("lane result outside of a product");

  // All lanes run in lockstep.
  a_lane_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_tag[0].valid == lane_tag[3].valid && lane_tag[1].valid == lane_tag[2].valid
    && lane_tag[0].valid == lane_tag[1].valid)
    else $error("lanes out of step");

  // The angle unit finishes only while the sequencer waits for it.
  a_angle_done: assert property (@(posedge clk) disable iff (rst)
    sc_done |-> state == ST_ANGLE)
    else $error("unexpected sine/cosine completion");

  // A result appears only after a point transform has finished.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> $past(state == ST_DONE && op == OP_POINT))
    else $error("result without a point transform");

endmodule

FILE: design/atu_sincos.sv
module atu_sincos
  import atu_pkg::*;
#(
  parameter int DW    = 32,
  parameter int FRAC  = 16,
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [31:0]   angle,
  output logic                 done,
  output logic signed [DW-1:0] cs,
  output logic signed [DW-1:0] sn
);

  // The period 360 << FRAC equals 45 << (FRAC + 3), so the angle is reduced
  // by taking the upper bits modulo 45 (reciprocal multiplication) and
  // keeping the low SH bits as they are.
  localparam int UW = 48;
  localparam int SH = FRAC + 3;
  localparam int VW = 24;
  localparam logic [UW-1:0] PER      = UW'(360) << FRAC;
  localparam logic [UW-1:0] KOFF     = ((UW'(1) << 31) / PER + UW'(1)) * PER;
  localparam logic [UW-1:0] LOW_MASK = (UW'(1) << SH) - UW'(1);
  localparam logic [26:0]   RECIP45  = 27'd95443718;
  localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

  sc_state_t state, state_next;

  logic [UW-1:0]        u;
  logic [VW-6:0]        quo;
  logic                 cnt;
  logic [63:0]          prod;
  logic signed [ZW-1:0] z;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic [4:0]           step;
  logic                 flip;

  logic [VW-1:0]        v;
  logic [VW+26:0]       vm;
  logic [VW-1:0]        rem_v;
  logic signed [ZW-1:0] nd;
  logic signed [ZW-1:0] z_wrap;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_rnd;
  logic signed [XW-1:0] y_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE:   if (start) state_next = SC_REDUCE;
      SC_REDUCE: if (cnt) state_next = SC_SCALE;
      SC_SCALE:  state_next = SC_FOLD;
      SC_FOLD:   state_next = SC_ITER;
      SC_ITER:   if (step == LAST_STEP) state_next = SC_ROUND;
      SC_ROUND:  state_next = SC_IDLE;
      default:   state_next = SC_IDLE;
    endcase
  end

  assign v      = VW'(u >> SH);
  assign vm     = (VW+27)'(v) * (VW+27)'(RECIP45);
  assign rem_v  = v - (VW'(quo) * VW'(45));
  assign nd     = ZW'((prod + (64'd1 << (FRAC - 1))) >> FRAC);
  assign z_wrap = (nd > DEG180) ? nd - DEG360 : nd;
  assign dx     = y >>> step;
  assign dy     = x >>> step;
  assign x_rnd  = (x + (XW'(1) << (29 - FRAC))) >>> (30 - FRAC);
  assign y_rnd  = (y + (XW'(1) << (29 - FRAC))) >>> (30 - FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == SC_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SC_IDLE: begin
        u   <= {{(UW-32){angle[31]}}, angle} + KOFF;
        cnt <= 1'b0;
      end
      SC_REDUCE: begin
        if (!cnt) begin
          quo <= vm[VW+26:32];
        end else begin
          u <= (UW'(rem_v) << SH) | (u & LOW_MASK);
        end
        cnt <= 1'b1;
      end
      SC_SCALE: prod <= 64'(u[33:0]) * 64'(NANO);
      SC_FOLD: begin
        x    <= GAIN_Q30;
        y    <= '0;
        step <= '0;
        if (z_wrap > DEG90) begin
          z    <= z_wrap - DEG180;
          flip <= 1'b1;
        end else if (z_wrap < -DEG90) begin
          z    <= z_wrap + DEG180;
          flip <= 1'b1;
        end else begin
          z    <= z_wrap;
          flip <= 1'b0;
        end
      end
      SC_ITER: begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_nd(step);
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_nd(step);
        end
        step <= step + 5'd1;
      end
      SC_ROUND: begin
        cs <= flip ? DW'(-x_rnd) : DW'(x_rnd);
        sn <= flip ? DW'(-y_rnd) : DW'(y_rnd);
      end
      default: ;
    endcase
  end

endmodule

FILE: design/atu_lane.sv
module atu_lane
  import atu_pkg::*;
#(
  parameter int DW   = 32,
  parameter int FRAC = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_tag_t            issue,
  input  logic signed [DW-1:0] m_row [4],
  input  logic signed [DW-1:0] t_col [4],
  output lane_tag_t            res_tag,
  output logic signed [DW-1:0] res_val
);

  localparam int PW = 2 * DW + 1;
  localparam logic signed [DW+2:0] SMAX = (DW+3)'((DW+3)'(1) << (DW - 1)) - (DW+3)'(1);
  localparam logic signed [DW+2:0] SMIN = -SMAX - (DW+3)'(1);

  lane_tag_t             tag1;
  logic                  neg [4];
  logic [2*DW-1:0]       mag [4];
  logic [DW-1:0]         abs_m [4];
  logic [DW-1:0]         abs_t [4];
  logic [PW-1:0]         rnd [4];
  logic [DW:0]           lim [4];
  logic [DW:0]           q [4];
  logic signed [DW+2:0]  term [4];
  logic signed [DW+2:0]  sum;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      abs_m[k] = m_row[k][DW-1] ? DW'(-m_row[k]) : DW'(m_row[k]);
      abs_t[k] = t_col[k][DW-1] ? DW'(-t_col[k]) : DW'(t_col[k]);
    end
  end

  // First stage: sign and magnitude of each product.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      neg[k] <= m_row[k][DW-1] ^ t_col[k][DW-1];
      mag[k] <= (2*DW)'(abs_m[k]) * (2*DW)'(abs_t[k]);
    end
  end

  // Second stage: round half away from zero, clamp, sum and saturate.
  always_comb begin
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      rnd[k]  = ({1'b0, mag[k]} + (PW'(1) << (FRAC - 1))) >> FRAC;
      lim[k]  = ((DW+1)'(1) << (DW - 1)) - (DW+1)'(!neg[k]);
      q[k]    = (rnd[k] > PW'(lim[k])) ? lim[k] : rnd[k][DW:0];
      term[k] = neg[k] ? -$signed((DW+3)'(q[k])) : $signed((DW+3)'(q[k]));
      sum     = sum + term[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid    <= 1'b0;
      res_tag.valid <= 1'b0;
    end else begin
      tag1.valid    <= issue.valid;
      res_tag.valid <= tag1.valid;
    end
    tag1.col    <= issue.col;
    res_tag.col <= tag1.col;
    if (sum > SMAX) begin
      res_val <= DW'(SMAX);
    end else if (sum < SMIN) begin
      res_val <= DW'(SMIN);
    end else begin
      res_val <= DW'(sum);
    end
  end

endmodule
